/* sv/sliding_window_maximum_macros.svh */
// Assertion macros shared by the sliding window maximum modules.
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SWM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/swm_pkg.sv */
// Shared constants and types of the sliding window maximum block.
package swm_pkg;

	localparam int WINDOW_MAX_DEFAULT  = 64;
	localparam int SAMPLE_BITS_DEFAULT = 32;
	localparam int CFG_W               = 7;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

	typedef struct packed {
		logic step;
		logic clear;
		logic pop;
	} swm_cmd_t;

endpackage

/* sv/swm_cell.sv */
// One deque cell: holds a candidate value and its age, shifts toward the front.
module swm_cell #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  swm_pkg::swm_cmd_t                      cmd,
	input  logic signed [SAMPLE_BITS-1:0]          sample_value,
	input  logic                                   left_keep,
	input  logic                                   right_valid,
	input  logic [SAMPLE_BITS-1:0]                 right_value,
	input  logic [$clog2(WINDOW_MAX + 1)-1:0]      right_age,
	output logic                                   valid,
	output logic [SAMPLE_BITS-1:0]                 value,
	output logic [$clog2(WINDOW_MAX + 1)-1:0]      age,
	output logic                                   keep,
	output logic [SAMPLE_BITS-1:0]                 next_value
);
	import swm_pkg::*;

	localparam int AGE_W = $clog2(WINDOW_MAX + 1);

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] value_q;
	logic [AGE_W-1:0]       age_q;
	logic                   l_valid;
	logic [SAMPLE_BITS-1:0] l_value;
	logic [AGE_W-1:0]       l_age;
	logic                   keep_w;
	logic                   valid_d;
	logic [SAMPLE_BITS-1:0] value_d;
	logic [AGE_W-1:0]       age_d;

	always_comb begin
		l_valid = (cmd.pop ? right_valid : valid_q) && !cmd.clear;
		l_value = cmd.pop ? right_value : value_q;
		l_age   = cmd.pop ? right_age : age_q;
		keep_w  = l_valid && ($signed(l_value) > sample_value);
		valid_d = valid_q;
		value_d = value_q;
		age_d   = age_q;
		if (cmd.step) begin
			valid_d = keep_w || left_keep;
			value_d = keep_w ? l_value : sample_value;
			age_d   = keep_w ? l_age + AGE_W'(1) : AGE_W'(1);
		end else if (cmd.pop) begin
			valid_d = right_valid;
			value_d = right_value;
			age_d   = right_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		age_q   <= age_d;
	end

	assign valid      = valid_q;
	assign value      = value_q;
	assign age        = age_q;
	assign keep       = keep_w;
	assign next_value = value_d;

endmodule

/* sv/swm_ctrl.sv */
// Handshake, window size register, fill tracking and result register.
`include "sliding_window_maximum_macros.svh"

module swm_ctrl #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   start_sequence,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [SAMPLE_BITS-1:0]          window_max,
	input  logic                                   window_size_we,
	input  logic [swm_pkg::CFG_W-1:0]              window_size,
	input  logic                                   front_valid,
	input  logic [$clog2(WINDOW_MAX + 1)-1:0]      front_age,
	input  logic [SAMPLE_BITS-1:0]                 front_next_value,
	output swm_pkg::swm_cmd_t                      cmd
);
	import swm_pkg::*;

	localparam int AGE_W = $clog2(WINDOW_MAX + 1);
	localparam int POS_W = AGE_W + 1;
	localparam int CMP_W = (AGE_W > CFG_W) ? AGE_W : CFG_W;

	logic [CFG_W-1:0]       window_size_q;
	logic [AGE_W-1:0]       pos_q;
	logic                   filled_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] window_max_q;
	logic [CMP_W-1:0]       ws_ext;
	logic [AGE_W-1:0]       w_eff;
	logic                   front_old;
	logic                   trim;
	logic                   accept;
	logic [AGE_W-1:0]       base_pos;
	logic                   base_filled;
	logic [POS_W-1:0]       pos_inc;
	logic                   filled_d;

	always_comb begin
		ws_ext = CMP_W'(window_size_q);
		if (window_size_q == '0) begin
			w_eff = AGE_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
			w_eff = AGE_W'(WINDOW_MAX);
		end else begin
			w_eff = ws_ext[AGE_W-1:0];
		end
	end

	assign front_old   = front_valid && (front_age >= w_eff);
	assign trim        = front_valid && (front_age > w_eff);
	assign in_stall    = trim || (out_valid_q && out_stall);
	assign accept      = in_valid && !in_stall;
	assign base_pos    = start_sequence ? '0 : pos_q;
	assign base_filled = start_sequence ? 1'b0 : filled_q;
	assign pos_inc     = {1'b0, base_pos} + POS_W'(1);
	assign filled_d    = base_filled || (pos_inc >= {1'b0, w_eff});

	assign cmd.step  = accept;
	assign cmd.clear = accept && start_sequence;
	assign cmd.pop   = (accept || trim) && front_old;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
			pos_q         <= '0;
			filled_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (window_size_we) begin
				window_size_q <= window_size;
			end
			if (accept) begin
				filled_q <= filled_d;
				if (!filled_d) begin
					pos_q <= pos_inc[AGE_W-1:0];
				end
			end
			if (accept && filled_d) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && filled_d) begin
			window_max_q <= front_next_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	`SWM_ASSERT_NEXT(a_push_leaves_front, accept, front_valid, "deque empty after a request")
	`SWM_ASSERT_NEXT(a_filled_sticky, filled_q && !(accept && start_sequence), filled_q,
		"window filled flag dropped without a new sequence")
	`SWM_ASSERT_NEXT(a_unit_window_result, accept && (w_eff == AGE_W'(1)), out_valid_q,
		"no result for a one-sample window")

endmodule

/* sv/sliding_window_maximum.sv */
// Sliding window maximum over a signed sample stream, built as a row of deque cells.
//
// Channel  Dir  Handshake             Payload
// sample   in   in_valid / in_stall   sample_value, start_sequence
// result   out  out_valid / out_stall window_max
// config   in   window_size_we        window_size
//
// One sample per cycle is taken while in_stall is low; its result is registered with it.
// Every cell compares against the sample in parallel, so no window size slows the rate.
// After window_size is lowered, in_stall stays high while the front is trimmed of deque
// entries older than the new window.
// Reset empties the deque, clears the sequence and loads a window size of 3.
// A stalled result holds the output register and stalls the input side.
`include "sliding_window_maximum_macros.svh"

module sliding_window_maximum #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                          start_sequence,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	input  logic                          window_size_we,
	input  logic [swm_pkg::CFG_W-1:0]     window_size
);
	import swm_pkg::*;

	localparam int AGE_W = $clog2(WINDOW_MAX + 1);

	swm_cmd_t               cmd;
	logic [WINDOW_MAX:0]    cell_valid;
	logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX+1];
	logic [AGE_W-1:0]       cell_age [WINDOW_MAX+1];
	logic [WINDOW_MAX:0]    keep_chain;
	logic [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];

	assign keep_chain[0]          = 1'b1;
	assign cell_valid[WINDOW_MAX] = 1'b0;
	assign cell_value[WINDOW_MAX] = '0;
	assign cell_age[WINDOW_MAX]   = '0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell #(
			.WINDOW_MAX  (WINDOW_MAX),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.sample_value (sample_value),
			.left_keep    (keep_chain[i]),
			.right_valid  (cell_valid[i+1]),
			.right_value  (cell_value[i+1]),
			.right_age    (cell_age[i+1]),
			.valid        (cell_valid[i]),
			.value        (cell_value[i]),
			.age          (cell_age[i]),
			.keep         (keep_chain[i+1]),
			.next_value   (cell_next[i])
		);
	end

	swm_ctrl #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.start_sequence   (start_sequence),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.window_max       (window_max),
		.window_size_we   (window_size_we),
		.window_size      (window_size),
		.front_valid      (cell_valid[0]),
		.front_age        (cell_age[0]),
		.front_next_value (cell_next[0]),
		.cmd              (cmd)
	);

	`SWM_ASSERT_ALWAYS(a_deque_packed,
		(cell_valid[WINDOW_MAX:1] & ~cell_valid[WINDOW_MAX-1:0]) == '0,
		"gap in the deque cells")

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_check
		`SWM_ASSERT_IMPLY(a_values_decrease, cell_valid[i+1],
			$signed(cell_value[i]) > $signed(cell_value[i+1]),
			"deque values not strictly decreasing")
		`SWM_ASSERT_IMPLY(a_ages_decrease, cell_valid[i+1], cell_age[i] > cell_age[i+1],
			"deque ages out of order")
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module testbench;
	import swm_pkg::*;

	localparam int WINDOW_MAX    = WINDOW_MAX_DEFAULT;
	localparam int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT;
	localparam int POS_MOD       = 2 * WINDOW_MAX;
	localparam int SETTLE_CYCLES = WINDOW_MAX + 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 1350;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CFG_W-1:0] window_t;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_VALUE} check_t;
	typedef enum logic [2:0] {VAL_RANDOM, VAL_TIES, VAL_FALLING, VAL_RISING, VAL_EXTREME} value_mode_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct packed {
		row_kind_t kind;
		logic [31:0] value;
		logic start;
		check_t check;
		logic [31:0] max_value;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, CHECK_VALUE, 32'h7FFF_FFFF},
		'{ROW_SAMPLE, 32'h0000_0005, 1'b0, CHECK_VALUE, 32'h0000_0005},
		'{ROW_SAMPLE, 32'h0000_0005, 1'b0, CHECK_VALUE, 32'h0000_0005},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHECK_VALUE, 32'h0000_0005},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b1, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHECK_VALUE, 32'h8000_0000},
		'{ROW_SAMPLE, 32'h0000_0001, 1'b1, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h0000_0002, 1'b1, CHECK_NONE,  32'h0},
		'{ROW_WINDOW, 32'h0000_0000, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, CHECK_VALUE, 32'hFFFF_FFF9},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHECK_VALUE, 32'h7FFF_FFFF},
		'{ROW_WINDOW, 32'h0000_007F, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, CHECK_MODEL, 32'h0},
		'{ROW_SAMPLE, 32'h5555_5555, 1'b1, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_WINDOW, 32'h0000_0002, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h0000_0000, 1'b0, CHECK_MODEL, 32'h0},
		'{ROW_WINDOW, 32'h0000_0003, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h0000_0009, 1'b1, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'hFFFF_FFF7, 1'b0, CHECK_NONE,  32'h0},
		'{ROW_SAMPLE, 32'h0000_0009, 1'b0, CHECK_VALUE, 32'h0000_0009}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t sample_value = '0;
	logic start_sequence = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	sample_t window_max;
	logic window_size_we = 1'b0;
	window_t window_size = '0;

	sliding_window_maximum dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_value(sample_value),
		.start_sequence(start_sequence),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window_max(window_max),
		.window_size_we(window_size_we),
		.window_size(window_size)
	);

	always #2 clk = ~clk;

	// Predictor state: a ring of candidate peaks, decreasing from head to tail.
	sample_t peak_val [WINDOW_MAX];
	int unsigned peak_pos [WINDOW_MAX];
	int unsigned peak_head = 0;
	int unsigned peak_count = 0;
	int unsigned stream_pos = 0;
	bit window_full = 1'b0;
	window_t window_len = WINDOW_SIZE_RESET;

	sample_t expected_maxima [$];
	int unsigned errors = 0;
	int unsigned maxima_checked = 0;
	int unsigned requests_sent = 0;
	int unsigned window_writes = 0;
	int unsigned burst_left = 0;
	sample_t ramp_value = '0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_left = 0;
	int unsigned stall_tick = 0;

	function automatic bit predict_window_max(input sample_t v, input logic start,
			output sample_t peak);
		int unsigned w;
		int unsigned pos;
		int unsigned slot;
		w = window_len;
		if (w == 0) w = 1;
		if (w > WINDOW_MAX) w = WINDOW_MAX;
		if (start) begin
			peak_head = 0;
			peak_count = 0;
			stream_pos = 0;
			window_full = 1'b0;
		end
		pos = stream_pos % POS_MOD;
		while (peak_count > 0 && ((pos + POS_MOD - peak_pos[peak_head]) % POS_MOD) >= w) begin
			peak_head = (peak_head + 1) % WINDOW_MAX;
			peak_count--;
		end
		while (peak_count > 0 && peak_val[(peak_head + peak_count - 1) % WINDOW_MAX] <= v)
			peak_count--;
		if (peak_count >= WINDOW_MAX) begin
			peak_head = (peak_head + 1) % WINDOW_MAX;
			peak_count--;
		end
		slot = (peak_head + peak_count) % WINDOW_MAX;
		peak_val[slot] = v;
		peak_pos[slot] = pos;
		peak_count++;
		if (!window_full && pos + 1 >= w) window_full = 1'b1;
		stream_pos = (pos + 1) % POS_MOD;
		peak = peak_val[peak_head];
		return window_full;
	endfunction

	function automatic sample_t next_value(input value_mode_t mode);
		case (mode)
			VAL_RANDOM: return $urandom;
			VAL_TIES: return $signed($urandom_range(0, 6)) - 3;
			VAL_FALLING: begin
				ramp_value = ramp_value - $urandom_range(0, 3);
				return ramp_value;
			end
			VAL_RISING: begin
				ramp_value = ramp_value + $urandom_range(0, 3);
				return ramp_value;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
					1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
					2: return '0;
					3: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic send_sample(input sample_t v, input logic start, input check_t check,
			input sample_t typed_max);
		int unsigned gap;
		sample_t peak;
		bit has_result;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		sample_value <= v;
		start_sequence <= start;
		do @(posedge clk); while (in_stall);
		burst_left--;
		requests_sent++;
		has_result = predict_window_max(v, start, peak);
		case (check)
			CHECK_MODEL: if (has_result) expected_maxima.insert(expected_maxima.size(), peak);
			CHECK_VALUE: expected_maxima.insert(expected_maxima.size(), typed_max);
			default: ;
		endcase
	endtask

	// The block must be idle before a window size write.
	task automatic write_window(input window_t ws);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_maxima.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		window_size_we <= 1'b1;
		window_size <= ws;
		@(posedge clk);
		window_len = ws;
		window_writes++;
		@(negedge clk);
		window_size_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 80);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_tick[2];
		endcase
	end

	always @(posedge clk) begin
		sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_maxima.size() == 0) begin
				errors++;
				$display("%0t: window_max expected none, got %0d", $time, window_max);
			end else begin
				want = expected_maxima[0];
				expected_maxima.delete(0);
				maxima_checked++;
				if (window_max !== want) begin
					errors++;
					$display("%0t: window_max expected %0d, got %0d", $time, want, window_max);
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		window_t ws;
		int unsigned eff;
		int unsigned len;
		int unsigned random_sent;
		value_mode_t mode;
		logic start;
		random_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_WINDOW)
				write_window(row.value[CFG_W-1:0]);
			else
				send_sample(row.value, row.start, row.check, row.max_value);
		end

		// Each phase picks a window size, then streams sequences of one value shape.
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: ws = '0;
				1: ws = '1;
				2: ws = window_t'(WINDOW_MAX);
				3: ws = window_t'($urandom_range(0, 127));
				default: ws = window_t'($urandom_range(1, 12));
			endcase
			write_window(ws);
			eff = (ws == 0) ? 1 : ((ws > WINDOW_MAX) ? WINDOW_MAX : ws);
			len = (eff > 16) ? $urandom_range(80, 180) : $urandom_range(12, 60);
			if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
			mode = value_mode_t'($urandom_range(0, 4));
			ramp_value = $urandom;
			for (int k = 0; k < len; k++) begin
				if (k == 0)
					start = $urandom_range(0, 1);
				else
					start = ($urandom_range(0, 3 * eff + 6) == 0);
				send_sample(next_value(mode), start, CHECK_MODEL, '0);
				random_sent++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && expected_maxima.size() != 0; i++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_maxima.size() != 0) begin
			errors += expected_maxima.size();
			$display("%0t: %0d window maxima never arrived", $time, expected_maxima.size());
		end
		$display("Streamed %0d sample requests over %0d window size settings,",
			requests_sent, window_writes + 1);
		$display("including zero, full and oversize windows; %0d maxima compared.", maxima_checked);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d window maxima outstanding", expected_maxima.size());
		$display("Verification failed");
		$finish;
	end

endmodule

/* sliding_window_maximum.f */
+incdir+sv
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_ctrl.sv
sv/sliding_window_maximum.sv
tb/testbench.sv
